>>> sv/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ax25hp_pkg.sv
// shared constants and types of the ax.25 header parser
// no dependencies; used by collector, decoder, top level and checker
`default_nettype none

package ax25hp_pkg;

  localparam int MAX_DIGIS = 8;
  localparam int MAX_FRAME = 4096;

  localparam int ADDR_LEN  = 14;
  localparam int DIGI_LEN  = 7;
  localparam int FLEX_LEN  = 7;
  localparam int FLEX_BYTE = 1;
  localparam int DEST_SSID = 6;
  localparam int SRC_SSID  = 13;
  localparam int MIN_FRAME  = 8;
  localparam int MIN_NORMAL = 15;

  // bytes kept after the address: control (up to two) plus three info bytes
  localparam int REL_BYTES = 5;
  localparam int REL_W     = $clog2(REL_BYTES + 1);
  localparam int REL_IW    = $clog2(REL_BYTES);

  localparam int POS_W  = $clog2(MAX_FRAME + 1);
  localparam int OFF_W  = $clog2(ADDR_LEN + DIGI_LEN * MAX_DIGIS + 1);
  localparam int DIGI_W = 4;
  localparam int PLEN_W = 12;

  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_FLEX   = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;
  localparam logic [1:0] ST_NOCTL  = 2'd3;

  localparam logic [1:0] CR_UNKNOWN = 2'd0;
  localparam logic [1:0] CR_CMD     = 2'd1;
  localparam logic [1:0] CR_RESP    = 2'd2;

  localparam logic [7:0] TYPE_I    = 8'h00;
  localparam logic [7:0] TYPE_UI   = 8'h03;
  localparam logic [7:0] TYPE_FRMR = 8'h87;
  localparam logic [7:0] TYPE_SABM = 8'h2F;
  localparam logic [7:0] TYPE_UA   = 8'h63;

  localparam logic [7:0] PID_FRAG = 8'h08;
  localparam logic [8:0] PID_NONE = 9'd256;

  // what the collector hands over at the end of a frame
  typedef struct packed {
    logic [POS_W-1:0]             len;
    logic                         flex;
    logic                         flex_cr;
    logic                         dest_hi;
    logic [2:0]                   src_bits;  // source ssid bits 7..5
    logic                         addr_done;
    logic                         overrun;
    logic [OFF_W-1:0]             off;
    logic [DIGI_W-1:0]            digis;
    logic [REL_BYTES-1:0][7:0]    rb;
  } frame_sum_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        cmd_resp;
    logic              extended;
    logic              dama;
    logic [DIGI_W-1:0] digi_count;
    logic [7:0]        frame_type;
    logic [6:0]        send_seq;
    logic [6:0]        recv_seq;
    logic              poll_final;
    logic [8:0]        protocol_id;
    logic [23:0]       extra_info;
    logic [PLEN_W-1:0] info_length;
  } result_t;

endpackage

`default_nettype wire

>>> sv/ax25hp_collect.sv
// per-byte collector: tracks address end, digipeaters and keeps bytes after the address
// depends on ax25hp_pkg
`default_nettype none

module ax25hp_collect (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             byte_value,
  input  logic                   last_byte,
  output ax25hp_pkg::frame_sum_t summary
);

  logic [ax25hp_pkg::POS_W-1:0]               pos, pos_next;
  logic                                       flex, flex_next;
  logic                                       flex_cr, flex_cr_next;
  logic                                       dest_hi, dest_hi_next;
  logic [2:0]                                 src_bits, src_bits_next;
  logic                                       addr_done, addr_done_next;
  logic                                       overrun, overrun_next;
  logic [ax25hp_pkg::OFF_W-1:0]               off, off_next;
  logic [ax25hp_pkg::DIGI_W-1:0]              digis, digis_next;
  logic [ax25hp_pkg::OFF_W-1:0]               field_end, field_end_next;
  logic [ax25hp_pkg::REL_W-1:0]               rel, rel_next;
  logic [ax25hp_pkg::REL_BYTES-1:0][7:0]      rb, rb_next;

  always_comb begin
    pos_next       = (pos == ax25hp_pkg::POS_W'(ax25hp_pkg::MAX_FRAME)) ? pos
                     : pos + ax25hp_pkg::POS_W'(1);
    flex_next      = flex;
    flex_cr_next   = flex_cr;
    dest_hi_next   = dest_hi;
    src_bits_next  = src_bits;
    addr_done_next = addr_done;
    overrun_next   = overrun;
    off_next       = off;
    digis_next     = digis;
    field_end_next = field_end;
    rel_next       = rel;
    rb_next        = rb;

    if (pos == ax25hp_pkg::POS_W'(ax25hp_pkg::FLEX_BYTE)) begin
      flex_next    = byte_value[0];
      flex_cr_next = byte_value[1];
    end
    if (pos == ax25hp_pkg::POS_W'(ax25hp_pkg::DEST_SSID)) begin
      dest_hi_next = byte_value[7];
    end
    if (pos == ax25hp_pkg::POS_W'(ax25hp_pkg::SRC_SSID)) begin
      src_bits_next = byte_value[7:5];
    end

    if (addr_done) begin
      if (rel < ax25hp_pkg::REL_W'(ax25hp_pkg::REL_BYTES)) begin
        rb_next[rel[ax25hp_pkg::REL_IW-1:0]] = byte_value;
        rel_next = rel + ax25hp_pkg::REL_W'(1);
      end
    end else if (!overrun) begin
      if (flex_next) begin
        if (pos == ax25hp_pkg::POS_W'(ax25hp_pkg::FLEX_LEN - 1)) begin
          addr_done_next = 1'b1;
          off_next       = ax25hp_pkg::OFF_W'(ax25hp_pkg::FLEX_LEN);
        end
      end else if (pos == ax25hp_pkg::POS_W'(field_end)) begin
        // the source field ends at the first boundary, digipeaters after it
        if (pos != ax25hp_pkg::POS_W'(ax25hp_pkg::SRC_SSID)) begin
          digis_next = digis + ax25hp_pkg::DIGI_W'(1);
        end
        if (byte_value[0]) begin
          addr_done_next = 1'b1;
          off_next       = ax25hp_pkg::OFF_W'(pos + ax25hp_pkg::POS_W'(1));
        end else if (digis_next == ax25hp_pkg::DIGI_W'(ax25hp_pkg::MAX_DIGIS)) begin
          overrun_next = 1'b1;
        end else begin
          field_end_next = field_end + ax25hp_pkg::OFF_W'(ax25hp_pkg::DIGI_LEN);
        end
      end
    end
  end

  always_comb begin
    summary.len       = pos_next;
    summary.flex      = flex_next;
    summary.flex_cr   = flex_cr_next;
    summary.dest_hi   = dest_hi_next;
    summary.src_bits  = src_bits_next;
    summary.addr_done = addr_done_next;
    summary.overrun   = overrun_next;
    summary.off       = off_next;
    summary.digis     = digis_next;
    summary.rb        = rb_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      pos       <= '0;
      addr_done <= 1'b0;
      overrun   <= 1'b0;
      digis     <= '0;
      field_end <= ax25hp_pkg::OFF_W'(ax25hp_pkg::SRC_SSID);
      rel       <= '0;
    end else if (take) begin
      pos       <= pos_next;
      addr_done <= addr_done_next;
      overrun   <= overrun_next;
      digis     <= digis_next;
      field_end <= field_end_next;
      rel       <= rel_next;
    end
  end

  // header bytes are always written before a decode reads them
  always_ff @(posedge clk) begin
    if (take) begin
      flex     <= flex_next;
      flex_cr  <= flex_cr_next;
      dest_hi  <= dest_hi_next;
      src_bits <= src_bits_next;
      off      <= off_next;
      rb       <= rb_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/ax25hp_decode.sv
// header decode of one frame summary: address form, control field, pid and extras
// depends on ax25hp_pkg
`default_nettype none

module ax25hp_decode (
  input  ax25hp_pkg::frame_sum_t summary,
  output ax25hp_pkg::result_t    result
);

  logic                         normal;
  logic                         bad;
  logic                         ext;
  logic [ax25hp_pkg::POS_W-1:0] rem;
  logic [ax25hp_pkg::POS_W-1:0] left;
  logic [ax25hp_pkg::POS_W-1:0] plen;
  logic                         two_ctl;
  logic [7:0]                   b0, b1, pb0, pb1, pb2;
  logic [7:0]                   ftype;

  always_comb begin
    normal  = !summary.flex;
    ext     = normal && !summary.src_bits[1];
    rem     = summary.len - ax25hp_pkg::POS_W'(summary.off);
    b0      = summary.rb[0];
    b1      = summary.rb[1];
    two_ctl = 1'b0;
    ftype   = 8'h00;

    bad = (summary.len < ax25hp_pkg::POS_W'(ax25hp_pkg::MIN_FRAME)) ||
          (normal && ((summary.len < ax25hp_pkg::POS_W'(ax25hp_pkg::MIN_NORMAL)) ||
                      !summary.addr_done || summary.overrun));

    plen = (rem >= ax25hp_pkg::POS_W'(2)) ? rem - ax25hp_pkg::POS_W'(2) : '0;
    if (plen > ax25hp_pkg::POS_W'(4095)) begin
      plen = ax25hp_pkg::POS_W'(4095);
    end

    result             = '0;
    result.status      = normal ? ax25hp_pkg::ST_NORMAL : ax25hp_pkg::ST_FLEX;
    result.extended    = ext;
    result.dama        = normal && !summary.src_bits[0];
    result.digi_count  = normal ? summary.digis : '0;
    result.protocol_id = ax25hp_pkg::PID_NONE;
    result.info_length = plen[ax25hp_pkg::PLEN_W-1:0];

    if (!normal) begin
      result.cmd_resp = summary.flex_cr ? ax25hp_pkg::CR_CMD : ax25hp_pkg::CR_RESP;
    end else if (summary.dest_hi && !summary.src_bits[2]) begin
      result.cmd_resp = ax25hp_pkg::CR_CMD;
    end else if (summary.src_bits[2] && !summary.dest_hi) begin
      result.cmd_resp = ax25hp_pkg::CR_RESP;
    end else begin
      result.cmd_resp = ax25hp_pkg::CR_UNKNOWN;
    end

    // control field
    if (!b0[0]) begin
      ftype = ax25hp_pkg::TYPE_I;
      if (ext) begin
        two_ctl           = 1'b1;
        result.send_seq   = b0[7:1];
        result.recv_seq   = b1[7:1];
        result.poll_final = b1[0];
      end else begin
        result.send_seq   = {4'd0, b0[3:1]};
        result.recv_seq   = {4'd0, b0[7:5]};
        result.poll_final = b0[4];
      end
    end else if (b0[1]) begin
      ftype             = b0 & 8'hEF;
      result.poll_final = b0[4];
    end else if (ext) begin
      two_ctl           = 1'b1;
      ftype             = b0;
      result.recv_seq   = b1[7:1];
      result.poll_final = b1[0];
    end else begin
      ftype             = b0 & 8'h0F;
      result.recv_seq   = {4'd0, b0[7:5]};
      result.poll_final = b0[4];
    end
    result.frame_type = ftype;

    left = rem - (two_ctl ? ax25hp_pkg::POS_W'(2) : ax25hp_pkg::POS_W'(1));
    pb0  = two_ctl ? summary.rb[2] : summary.rb[1];
    pb1  = two_ctl ? summary.rb[3] : summary.rb[2];
    pb2  = two_ctl ? summary.rb[4] : summary.rb[3];

    if (ftype == ax25hp_pkg::TYPE_I || ftype == ax25hp_pkg::TYPE_UI) begin
      if (left != '0) begin
        result.protocol_id = {1'b0, pb0};
        if (pb0 == ax25hp_pkg::PID_FRAG && left >= ax25hp_pkg::POS_W'(2)) begin
          result.extra_info = {16'd0, pb1};
          if (pb1[7]) begin
            result.protocol_id = (left >= ax25hp_pkg::POS_W'(3)) ? {1'b0, pb2}
                                 : ax25hp_pkg::PID_NONE;
          end
        end
      end
    end else if (ftype == ax25hp_pkg::TYPE_FRMR) begin
      if (left >= ax25hp_pkg::POS_W'(3)) begin
        result.extra_info = {pb0, pb1, pb2};
      end
    end else if (ftype == ax25hp_pkg::TYPE_SABM || ftype == ax25hp_pkg::TYPE_UA) begin
      if (left >= ax25hp_pkg::POS_W'(2)) begin
        result.extra_info = {8'd0, pb0, pb1};
      end
    end

    // address only: keep the address flags, drop everything else
    if (!bad && rem == '0) begin
      result.status      = ax25hp_pkg::ST_NOCTL;
      result.frame_type  = '0;
      result.send_seq    = '0;
      result.recv_seq    = '0;
      result.poll_final  = 1'b0;
      result.protocol_id = ax25hp_pkg::PID_NONE;
      result.extra_info  = '0;
      result.info_length = '0;
    end

    // a two-byte control field cut short counts as a bad header
    if (bad || (rem != '0 && two_ctl && rem < ax25hp_pkg::POS_W'(2))) begin
      result             = '0;
      result.status      = ax25hp_pkg::ST_BAD;
      result.protocol_id = ax25hp_pkg::PID_NONE;
    end
  end

endmodule

`default_nettype wire

>>> sv/ax25_header_parser_unit.sv
// top level of the ax.25 header parser: byte collector, summary register, decoder,
// output register. depends on ax25hp_pkg, ax25hp_collect, ax25hp_decode
//
//   channel  handshake             fields                  moves
//   in       in_valid, in_ready    byte_value, last_byte   one frame byte per request
//   out      out_valid, out_ready  status .. info_length   one header summary per frame
//
// one byte is taken per cycle while in_ready is high, frames back to back with no gap.
// a frame's summary is captured in the summary register with its last byte, then goes
// through the decode into the output register.
// the output register and the summary register each hold one frame, so input
// stalls only when both are full and out_ready is low.
// synchronous reset clears the collector and both valid flags; no clearing pass.
`default_nettype none

module ax25_header_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [1:0]  cmd_resp,
  output logic        extended,
  output logic        dama,
  output logic [3:0]  digi_count,
  output logic [7:0]  frame_type,
  output logic [6:0]  send_seq,
  output logic [6:0]  recv_seq,
  output logic        poll_final,
  output logic [8:0]  protocol_id,
  output logic [23:0] extra_info,
  output logic [11:0] info_length
);

  ax25hp_pkg::frame_sum_t summary_in;
  ax25hp_pkg::frame_sum_t summary;
  ax25hp_pkg::result_t    decoded;
  ax25hp_pkg::result_t    result;
  logic                   sum_valid;
  logic                   out_load;
  logic                   in_take;

  assign out_load = !out_valid || out_ready;
  assign in_ready = !sum_valid || out_load;
  assign in_take  = in_valid && in_ready;

  ax25hp_collect u_collect (
    .clk        (clk),
    .rst        (rst),
    .take       (in_take),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .summary    (summary_in)
  );

  ax25hp_decode u_decode (
    .summary (summary),
    .result  (decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take && last_byte) begin
        sum_valid <= 1'b1;
      end else if (out_load) begin
        sum_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && last_byte) begin
      summary <= summary_in;
    end
    if (out_load) begin
      result <= decoded;
    end
  end

  assign status      = result.status;
  assign cmd_resp    = result.cmd_resp;
  assign extended    = result.extended;
  assign dama        = result.dama;
  assign digi_count  = result.digi_count;
  assign frame_type  = result.frame_type;
  assign send_seq    = result.send_seq;
  assign recv_seq    = result.recv_seq;
  assign poll_final  = result.poll_final;
  assign protocol_id = result.protocol_id;
  assign extra_info  = result.extra_info;
  assign info_length = result.info_length;

endmodule

`default_nettype wire

>>> sv/ax25hp_checker.sv
// port-level checks of the ax.25 header parser, bound to the top level
// depends on ax25hp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ax25hp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [1:0]  cmd_resp,
  input logic        extended,
  input logic        dama,
  input logic [3:0]  digi_count,
  input logic [7:0]  frame_type,
  input logic [8:0]  protocol_id,
  input logic [23:0] extra_info,
  input logic [11:0] info_length
);

  // a stalled result holds
  `AST_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(extra_info) && $stable(info_length),
    "stalled result changed")

  // a bad header carries nothing but its status
  `AST_IMPLY(a_bad_empty, clk, rst, out_valid && status == ax25hp_pkg::ST_BAD,
    protocol_id == ax25hp_pkg::PID_NONE && info_length == 12'd0 &&
    digi_count == 4'd0 && extra_info == 24'd0 && cmd_resp == ax25hp_pkg::CR_UNKNOWN,
    "bad header result not cleared")

  // address-only frame has no control or pid
  `AST_IMPLY(a_noctl_empty, clk, rst, out_valid && status == ax25hp_pkg::ST_NOCTL,
    frame_type == 8'd0 && protocol_id == ax25hp_pkg::PID_NONE && info_length == 12'd0,
    "no-control result carries control data")

  // compressed header has no digipeaters and no normal-header flags
  `AST_IMPLY(a_flex_flags, clk, rst, out_valid && status == ax25hp_pkg::ST_FLEX,
    !extended && !dama && digi_count == 4'd0 && cmd_resp != ax25hp_pkg::CR_UNKNOWN,
    "compressed header with normal-header flags")

  // digipeater count stays within the limit
  `AST_IMPLY(a_digi_limit, clk, rst, out_valid,
    digi_count <= 4'(ax25hp_pkg::MAX_DIGIS),
    "digipeater count over limit")

endmodule

bind ax25_header_parser_unit ax25hp_checker u_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for ax25_header_parser_unit: random and directed frames, a
// scoreboard of predicted header summaries, random stalls on both channels
// depends on ax25hp_pkg and the parser rtl
`default_nettype none

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int STORE_LEN   = ax25hp_pkg::ADDR_LEN
                               + ax25hp_pkg::DIGI_LEN * ax25hp_pkg::MAX_DIGIS + 8;

  localparam logic [7:0] PF_MASK = 8'h10;
  localparam logic [3:0] S_RR    = 4'h1;
  localparam logic [3:0] S_RNR   = 4'h5;
  localparam logic [3:0] S_REJ   = 4'h9;
  localparam logic [3:0] S_SREJ  = 4'hD;
  localparam logic [7:0] U_DISC  = 8'h43;
  localparam logic [7:0] U_DM    = 8'h0F;
  localparam logic [7:0] U_SABME = 8'h6F;
  localparam logic [7:0] U_XID   = 8'hAF;
  localparam logic [7:0] U_TEST  = 8'hE3;

  typedef struct {
    logic [7:0] value;
    logic       fin;
    bit         hold;    // wait for every summary before sending
    bit         steady;  // no idling on either side
  } link_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_value = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [1:0]  cmd_resp;
  logic        extended;
  logic        dama;
  logic [3:0]  digi_count;
  logic [7:0]  frame_type;
  logic [6:0]  send_seq;
  logic [6:0]  recv_seq;
  logic        poll_final;
  logic [8:0]  protocol_id;
  logic [23:0] extra_info;
  logic [11:0] info_length;
  ax25hp_pkg::result_t observed;

  link_byte_t  pending_bytes[$];
  logic [7:0]  frame_bytes[$];
  ax25hp_pkg::result_t expected_headers[$];
  logic [7:0]  frame_store [STORE_LEN];
  int          frame_len = 0;
  int          frames_in = 0;
  int          frames_out = 0;
  int          bytes_sent = 0;
  int          failures = 0;
  int          cycle_count = 0;
  int          status_seen [4];
  bit          no_gaps = 1'b0;

  ax25_header_parser_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .byte_value(byte_value), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .cmd_resp(cmd_resp), .extended(extended), .dama(dama),
    .digi_count(digi_count), .frame_type(frame_type), .send_seq(send_seq),
    .recv_seq(recv_seq), .poll_final(poll_final), .protocol_id(protocol_id),
    .extra_info(extra_info), .info_length(info_length)
  );

  assign observed = {status, cmd_resp, extended, dama, digi_count, frame_type, send_seq,
                     recv_seq, poll_final, protocol_id, extra_info, info_length};

  always #10 clk = ~clk;

  // ---------------- header summary predictor ----------------

  function automatic logic [7:0] store_at(int i);
    return (i < STORE_LEN) ? frame_store[i] : 8'h00;
  endfunction

  function automatic ax25hp_pkg::result_t decode_header(int len);
    ax25hp_pkg::result_t bad, r;
    int         off, rem, plen, ctlen, left, p;
    logic [7:0] fb, dst, src, ssid, b0, b1, seg;
    logic       addr_end;
    bad = '0;
    bad.status = ax25hp_pkg::ST_BAD;
    bad.protocol_id = ax25hp_pkg::PID_NONE;
    r = '0;
    r.protocol_id = ax25hp_pkg::PID_NONE;
    fb = store_at(ax25hp_pkg::FLEX_BYTE);
    dst = store_at(ax25hp_pkg::DEST_SSID);
    src = store_at(ax25hp_pkg::SRC_SSID);
    if (len < ax25hp_pkg::MIN_FRAME) return bad;
    if (fb[0]) begin
      r.status = ax25hp_pkg::ST_FLEX;
      r.cmd_resp = fb[1] ? ax25hp_pkg::CR_CMD : ax25hp_pkg::CR_RESP;
      off = ax25hp_pkg::FLEX_LEN;
    end else begin
      if (len < ax25hp_pkg::MIN_NORMAL) return bad;
      r.status = ax25hp_pkg::ST_NORMAL;
      r.extended = !src[6];
      r.dama = !src[5];
      if (dst[7] && !src[7]) r.cmd_resp = ax25hp_pkg::CR_CMD;
      else if (src[7] && !dst[7]) r.cmd_resp = ax25hp_pkg::CR_RESP;
      else r.cmd_resp = ax25hp_pkg::CR_UNKNOWN;
      addr_end = src[0];
      off = ax25hp_pkg::ADDR_LEN;
      while (!addr_end) begin
        if (r.digi_count >= ax25hp_pkg::MAX_DIGIS || off + ax25hp_pkg::DIGI_LEN > len)
          return bad;
        ssid = store_at(off + ax25hp_pkg::DIGI_LEN - 1);
        addr_end = ssid[0];
        r.digi_count = r.digi_count + 4'd1;
        off += ax25hp_pkg::DIGI_LEN;
      end
    end
    rem = len - off;
    plen = (rem >= 2) ? rem - 2 : 0;
    if (plen > 4095) plen = 4095;
    if (rem == 0) begin
      r.status = ax25hp_pkg::ST_NOCTL;
      return r;
    end
    b0 = store_at(off);
    b1 = store_at(off + 1);
    ctlen = 1;
    if (!b0[0]) begin
      r.frame_type = ax25hp_pkg::TYPE_I;
      if (r.extended) begin
        if (rem < 2) return bad;
        r.send_seq = b0[7:1];
        r.recv_seq = b1[7:1];
        r.poll_final = b1[0];
        ctlen = 2;
      end else begin
        r.send_seq = {4'd0, b0[3:1]};
        r.recv_seq = {4'd0, b0[7:5]};
        r.poll_final = b0[4];
      end
    end else if (b0[1]) begin
      r.frame_type = b0 & ~PF_MASK;
      r.poll_final = b0[4];
    end else if (r.extended) begin
      if (rem < 2) return bad;
      r.frame_type = b0;
      r.recv_seq = b1[7:1];
      r.poll_final = b1[0];
      ctlen = 2;
    end else begin
      r.frame_type = {4'h0, b0[3:0]};
      r.recv_seq = {4'd0, b0[7:5]};
      r.poll_final = b0[4];
    end
    p = off + ctlen;
    left = rem - ctlen;
    if (r.frame_type == ax25hp_pkg::TYPE_I || r.frame_type == ax25hp_pkg::TYPE_UI) begin
      if (left > 0) begin
        r.protocol_id = {1'b0, store_at(p)};
        if (store_at(p) == ax25hp_pkg::PID_FRAG && left >= 2) begin
          seg = store_at(p + 1);
          r.extra_info = {16'h0000, seg};
          // only the first segment carries the real pid
          if (seg[7])
            r.protocol_id = (left >= 3) ? {1'b0, store_at(p + 2)} : ax25hp_pkg::PID_NONE;
        end
      end
    end else if (r.frame_type == ax25hp_pkg::TYPE_FRMR && left >= 3) begin
      r.extra_info = {store_at(p), store_at(p + 1), store_at(p + 2)};
    end else if ((r.frame_type == ax25hp_pkg::TYPE_SABM
                  || r.frame_type == ax25hp_pkg::TYPE_UA) && left >= 2) begin
      r.extra_info = {8'h00, store_at(p), store_at(p + 1)};
    end
    r.info_length = 12'(plen);
    return r;
  endfunction

  task automatic take_frame_byte(logic [7:0] v, logic fin);
    if (frame_len < STORE_LEN) frame_store[frame_len] = v;
    if (frame_len < ax25hp_pkg::MAX_FRAME) frame_len++;
    if (fin) begin
      expected_headers.push_back(decode_header(frame_len));
      frame_len = 0;
      foreach (frame_store[i]) frame_store[i] = 8'h00;
    end
  endtask

  // ---------------- frame builders ----------------

  function automatic logic [7:0] call_char();
    return 8'($urandom) & 8'hFE;
  endfunction

  function automatic logic [3:0] pick_s();
    case ($urandom_range(0, 3))
      0: return S_RR;
      1: return S_RNR;
      2: return S_REJ;
      default: return S_SREJ;
    endcase
  endfunction

  function automatic logic [7:0] pick_u();
    case ($urandom_range(0, 8))
      0: return ax25hp_pkg::TYPE_UI;
      1: return ax25hp_pkg::TYPE_SABM;
      2: return ax25hp_pkg::TYPE_UA;
      3: return ax25hp_pkg::TYPE_FRMR;
      4: return U_DISC;
      5: return U_DM;
      6: return U_SABME;
      7: return U_XID;
      default: return U_TEST;
    endcase
  endfunction

  task automatic put_raw(logic [7:0] v);
    frame_bytes.push_back(v);
  endtask

  task automatic put_info(int n);
    for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom));
  endtask

  // src_top is source ssid bits 7..5: c bit, not-extended bit, dama spare bit
  task automatic put_address(logic dest_c, logic [2:0] src_top, int ndigis);
    for (int i = 0; i < 6; i++) frame_bytes.push_back(call_char());
    frame_bytes.push_back({dest_c, 2'b11, 4'($urandom), 1'b0});
    for (int i = 0; i < 6; i++) frame_bytes.push_back(call_char());
    frame_bytes.push_back({src_top, 4'($urandom), ndigis == 0});
    for (int d = 0; d < ndigis; d++) begin
      for (int i = 0; i < 6; i++) frame_bytes.push_back(call_char());
      frame_bytes.push_back({1'($urandom), 2'b11, 4'($urandom), d == ndigis - 1});
    end
  endtask

  task automatic put_flex(logic cr);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back({6'($urandom), cr, 1'b1});
    put_info(5);
  endtask

  task automatic put_pid();
    logic [7:0] seg;
    if ($urandom_range(0, 3) != 0) begin
      frame_bytes.push_back(8'($urandom));
    end else begin
      seg = 8'($urandom);
      frame_bytes.push_back(ax25hp_pkg::PID_FRAG);
      frame_bytes.push_back(seg);
      if (seg[7]) frame_bytes.push_back(8'($urandom));
    end
  endtask

  // control field, pid where it belongs, then a few info bytes
  task automatic put_body(logic ext);
    int         kind;
    logic       pf;
    logic [6:0] ns, nr;
    logic [7:0] u;
    kind = $urandom_range(0, 9);
    pf = 1'($urandom);
    ns = 7'($urandom);
    nr = 7'($urandom);
    if (kind < 4) begin
      if (ext) begin
        put_raw({ns, 1'b0});
        put_raw({nr, pf});
      end else begin
        put_raw({nr[2:0], pf, ns[2:0], 1'b0});
      end
      put_pid();
    end else if (kind < 6) begin
      if (ext) begin
        put_raw({4'($urandom), pick_s()});
        put_raw({nr, pf});
      end else begin
        put_raw({nr[2:0], pf, pick_s()});
      end
    end else begin
      u = pick_u();
      put_raw(pf ? (u | PF_MASK) : u);
      if (u == ax25hp_pkg::TYPE_UI) put_pid();
    end
    put_info(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6));
  endtask

  task automatic put_random_frame();
    int         pick, nd, keep;
    logic [2:0] src_top;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      repeat ($urandom_range(1, 24)) frame_bytes.push_back(8'($urandom));
    end else begin
      if ($urandom_range(0, 6) == 0) begin
        put_flex(1'($urandom));
        put_body(1'b0);
      end else begin
        nd = $urandom_range(0, 19);
        nd = (nd < 10) ? 0 : (nd < 15) ? 1 : (nd < 17) ? 2 :
             (nd < 19) ? $urandom_range(3, ax25hp_pkg::MAX_DIGIS)
             : ax25hp_pkg::MAX_DIGIS + 1;
        src_top = 3'($urandom);
        put_address(1'($urandom), src_top, nd);
        if ($urandom_range(0, 19) != 0) put_body(!src_top[1]);
      end
      // cut short somewhere
      if (pick >= 85) begin
        keep = $urandom_range(1, frame_bytes.size());
        while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end
    end
  endtask

  task automatic queue_frame(bit hold, bit steady);
    link_byte_t lb;
    foreach (frame_bytes[i]) begin
      lb.value = frame_bytes[i];
      lb.fin = (i == frame_bytes.size() - 1);
      lb.hold = hold && (i == 0);
      lb.steady = steady;
      pending_bytes.push_back(lb);
    end
    frame_bytes.delete();
  endtask

  // ---------------- checking ----------------

  function automatic void check_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      failures++;
    end
  endfunction

  function automatic void check_header(ax25hp_pkg::result_t want);
    check_field("status", want.status, observed.status);
    check_field("cmd_resp", want.cmd_resp, observed.cmd_resp);
    check_field("extended", want.extended, observed.extended);
    check_field("dama", want.dama, observed.dama);
    check_field("digi_count", want.digi_count, observed.digi_count);
    check_field("frame_type", want.frame_type, observed.frame_type);
    check_field("send_seq", want.send_seq, observed.send_seq);
    check_field("recv_seq", want.recv_seq, observed.recv_seq);
    check_field("poll_final", want.poll_final, observed.poll_final);
    check_field("protocol_id", want.protocol_id, observed.protocol_id);
    check_field("extra_info", want.extra_info, observed.extra_info);
    check_field("info_length", want.info_length, observed.info_length);
  endfunction

  // ---------------- byte driver ----------------

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        take_frame_byte(byte_value, last_byte);
        if (last_byte) frames_in <= frames_in + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0
            && (!pending_bytes[0].hold
                || frames_in + int'(in_valid && in_ready && last_byte) == frames_out)
            && (pending_bytes[0].steady || $urandom_range(0, 99) >= 31)) begin
          in_valid <= 1'b1;
          byte_value <= pending_bytes[0].value;
          last_byte <= pending_bytes[0].fin;
          no_gaps <= pending_bytes[0].steady;
          void'(pending_bytes.pop_front());
          bytes_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- summary monitor ----------------

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_headers.size() == 0) begin
          $error("header summary with no frame waiting for one");
          failures++;
        end else begin
          check_header(expected_headers.pop_front());
        end
        status_seen[status]++;
        frames_out <= frames_out + 1;
      end
      out_ready <= no_gaps || ($urandom_range(0, 99) >= 31);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  initial begin
    int random_frames;
    random_frames = 0;
    foreach (frame_store[i]) frame_store[i] = 8'h00;
    foreach (status_seen[i]) status_seen[i] = 0;

    // too short for any header
    put_raw(8'hFF);
    queue_frame(1'b0, 1'b0);
    repeat (7) put_raw(8'h00);
    queue_frame(1'b0, 1'b0);
    // shortest flexnet frame, all ones
    repeat (8) put_raw(8'hFF);
    queue_frame(1'b0, 1'b0);
    // flexnet response carrying an i frame
    put_flex(1'b0);
    put_raw(8'h00);
    put_raw(8'hF0);
    put_info(3);
    queue_frame(1'b0, 1'b0);
    // normal header one byte short
    repeat (14) put_raw(8'h00);
    queue_frame(1'b0, 1'b0);
    // address only, ending after one digipeater
    put_address(1'b1, 3'b000, 1);
    queue_frame(1'b0, 1'b0);
    // too many digipeaters
    put_address(1'b1, 3'b010, ax25hp_pkg::MAX_DIGIS + 1);
    put_raw(ax25hp_pkg::TYPE_UI);
    queue_frame(1'b0, 1'b0);
    // frame ends inside a digipeater field
    put_address(1'b0, 3'b100, 2);
    repeat (3) void'(frame_bytes.pop_back());
    queue_frame(1'b0, 1'b0);
    // full digipeater path, modulo-8 i frame
    put_address(1'b1, 3'b010, ax25hp_pkg::MAX_DIGIS);
    put_raw({3'd5, 1'b1, 3'd2, 1'b0});
    put_raw(8'hF0);
    put_info(4);
    queue_frame(1'b0, 1'b0);
    // extended control cut after its first byte
    put_address(1'b0, 3'b101, 0);
    put_raw(8'h00);
    queue_frame(1'b0, 1'b0);
    // from here through the handles, no idling on either side
    // extended i frame, sequence numbers at the top
    put_address(1'b1, 3'b000, 0);
    put_raw(8'hFE);
    put_raw(8'hFF);
    put_raw(8'hF0);
    put_info(2);
    queue_frame(1'b0, 1'b1);
    // extended s frame
    put_address(1'b0, 3'b100, 1);
    put_raw({4'hF, S_SREJ});
    put_raw(8'hFF);
    queue_frame(1'b0, 1'b1);
    // modulo-8 reject with poll
    put_address(1'b1, 3'b011, 0);
    put_raw({3'd7, 1'b1, S_REJ});
    queue_frame(1'b0, 1'b1);
    // segmented ui, first segment with its pid
    put_address(1'b1, 3'b011, 0);
    put_raw(ax25hp_pkg::TYPE_UI);
    put_raw(ax25hp_pkg::PID_FRAG);
    put_raw(8'h80);
    put_raw(8'hCC);
    put_info(3);
    queue_frame(1'b0, 1'b1);
    // segment byte missing
    put_address(1'b0, 3'b011, 0);
    put_raw(ax25hp_pkg::TYPE_UI | PF_MASK);
    put_raw(ax25hp_pkg::PID_FRAG);
    queue_frame(1'b0, 1'b1);
    // first segment with no pid behind it
    put_address(1'b1, 3'b010, 0);
    put_raw({3'd3, 1'b0, 3'd6, 1'b0});
    put_raw(ax25hp_pkg::PID_FRAG);
    put_raw(8'h81);
    queue_frame(1'b0, 1'b1);
    // later segment
    put_address(1'b1, 3'b011, 0);
    put_raw(ax25hp_pkg::TYPE_UI);
    put_raw(ax25hp_pkg::PID_FRAG);
    put_raw(8'h05);
    put_info(2);
    queue_frame(1'b0, 1'b1);
    // frmr with and without its three bytes
    put_address(1'b0, 3'b111, 0);
    put_raw(ax25hp_pkg::TYPE_FRMR | PF_MASK);
    put_raw(8'hAB);
    put_raw(8'hCD);
    put_raw(8'hEF);
    queue_frame(1'b0, 1'b1);
    put_address(1'b1, 3'b011, 0);
    put_raw(ax25hp_pkg::TYPE_FRMR);
    put_raw(8'h12);
    put_raw(8'h34);
    queue_frame(1'b0, 1'b1);
    // sabm and ua handles
    put_address(1'b1, 3'b011, 0);
    put_raw(ax25hp_pkg::TYPE_SABM);
    put_raw(8'h5A);
    put_raw(8'hA5);
    queue_frame(1'b0, 1'b1);
    put_address(1'b0, 3'b111, 0);
    put_raw(ax25hp_pkg::TYPE_UA | PF_MASK);
    put_raw(8'hFF);
    put_raw(8'hFF);
    queue_frame(1'b0, 1'b1);
    put_address(1'b1, 3'b011, 0);
    put_raw(U_DISC | PF_MASK);
    queue_frame(1'b0, 1'b0);
    // ui frame sent only once everything has drained
    put_address(1'b1, 3'b011, 0);
    put_raw(ax25hp_pkg::TYPE_UI);
    put_raw(8'hF0);
    put_info(24);
    queue_frame(1'b1, 1'b0);

    while (pending_bytes.size() < 500 || random_frames < 2) begin
      put_random_frame();
      random_frames++;
      queue_frame(1'b0, 1'b0);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid || frames_in != frames_out)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_headers.size() != 0) begin
      $error("%0d frames never got a header summary", expected_headers.size());
      failures++;
    end

    $display("summary: %0d bytes in %0d frames, %0d headers checked", bytes_sent, frames_in,
             frames_out);
    $display("summary: normal %0d, flexnet %0d, bad %0d, no control field %0d",
             status_seen[ax25hp_pkg::ST_NORMAL], status_seen[ax25hp_pkg::ST_FLEX],
             status_seen[ax25hp_pkg::ST_BAD], status_seen[ax25hp_pkg::ST_NOCTL]);
    if (failures == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
